// ===== hw/rtl/cmse_pkg.sv =====
// ----------------------------------------------------------------------------
// cmse_pkg
// Shared types and constants of the cartridge mapper with serial EEPROM.
// ----------------------------------------------------------------------------
package cmse_pkg;

  typedef enum logic [1:0] {
    REQ_CPU_WRITE = 2'd0,
    REQ_CPU_READ  = 2'd1,
    REQ_PPU_READ  = 2'd2,
    REQ_TICK      = 2'd3
  } req_type_t;

  typedef enum logic [5:0] {
    MODE_STANDBY      = 6'b000001,
    MODE_STANDBY_END  = 6'b000010,
    MODE_RW_SELECT    = 6'b000100,
    MODE_WAIT_ADDRESS = 6'b001000,
    MODE_WAIT_DATA    = 6'b010000,
    MODE_OUTPUT       = 6'b100000
  } serial_mode_t;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_128     = 2'd1,
    KIND_256     = 2'd2
  } chip_kind_t;

  localparam logic [0:0] CFG_PRG_PAGE_COUNT  = 1'd0;
  localparam logic [0:0] CFG_CHR_ROM_PRESENT = 1'd1;
  localparam int         CFG_DATA_W          = 9;

  localparam logic [15:0] ADDR_SAVE_BASE = 16'h6000;
  localparam logic [7:0]  LN_SCL         = 8'h20;
  localparam logic [7:0]  LN_SDA         = 8'h40;

  // classified request handed from front to back
  typedef struct packed {
    logic       wr_low;    // cpu write that loads a mapper register
    logic       wr_serial; // cpu write to the line register
    logic       rd_prg;
    logic       rd_save;
    logic       rd_ppu;
    logic       tick;
    logic [3:0] nib;
    logic [15:0] address;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [7:0] mirror_byte(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [3:0] nt_map(input logic [1:0] m);
    logic [3:0] r;
    unique case (m)
      2'd0: r = 4'hC;
      2'd1: r = 4'hA;
      2'd2: r = 4'h0;
      default: r = 4'hF;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/cmse_if.sv =====
// ----------------------------------------------------------------------------
// cmse_in_if / cmse_out_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
interface cmse_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] address;
  logic [7:0]  data;
  modport source (output valid, req_type, address, data, input ready);
  modport sink   (input valid, req_type, address, data, output ready);
endinterface

interface cmse_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        prg_hit;
  logic [21:0] prg_address;
  logic [17:0] chr_address;
  logic [3:0]  nametable_map;
  logic        irq_line;
  modport source (output valid, read_data, prg_hit, prg_address, chr_address,
                  nametable_map, irq_line, input ready);
  modport sink   (input valid, read_data, prg_hit, prg_address, chr_address,
                  nametable_map, irq_line, output ready);
endinterface

// ===== hw/rtl/cmse_ram.sv =====
// ----------------------------------------------------------------------------
// cmse_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module cmse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/cmse_front.sv =====
// ----------------------------------------------------------------------------
// cmse_front
// Classify incoming requests into a two-entry queue.
// ----------------------------------------------------------------------------
module cmse_front (
  input  logic             clk,
  input  logic             rst_n,
  cmse_in_if.sink          in_ch,
  output logic             q_valid,
  output cmse_pkg::cmd_t   q_cmd,
  input  logic             q_pop
);
  cmse_pkg::cmd_t   ent_r [2];
  logic             rd_ptr_r, wr_ptr_r;
  logic [1:0]       cnt_r;
  cmse_pkg::cmd_t   cls;
  logic             push;
  logic             hi;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_cmd       = ent_r[rd_ptr_r];
  assign hi          = (in_ch.address >= cmse_pkg::ADDR_SAVE_BASE);

  always_comb begin
    cls           = '0;
    cls.nib       = in_ch.address[3:0];
    cls.address   = in_ch.address;
    cls.data      = in_ch.data;
    unique case (cmse_pkg::req_type_t'(in_ch.req_type))
      cmse_pkg::REQ_CPU_WRITE: begin
        cls.wr_serial = hi && (in_ch.address[3:0] == 4'hD);
        cls.wr_low    = hi && (in_ch.address[3:0] < 4'hD);
      end
      cmse_pkg::REQ_CPU_READ: begin
        cls.rd_prg  = in_ch.address[15];
        cls.rd_save = hi && !in_ch.address[15];
      end
      cmse_pkg::REQ_PPU_READ: cls.rd_ppu = 1'b1;
      default:                cls.tick   = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push)  wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ===== hw/rtl/cmse_back.sv =====
// ----------------------------------------------------------------------------
// cmse_back
// Execute classified requests: mapper registers, IRQ counter, EEPROM.
// ----------------------------------------------------------------------------
module cmse_back #(
  parameter int SAVE_BYTES = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  cmse_pkg::cmd_t q_cmd,
  output logic           q_pop,
  input  logic [8:0]     prg_page_count,
  input  logic           chr_rom_present,
  cmse_out_if.source     out_ch
);
  localparam int AW = $clog2(SAVE_BYTES);

  // store cleared after reset by a sweep
  logic [AW:0]   clr_cnt_r;
  logic          clearing;

  logic [7:0]  chr_banks_r [8];
  logic [7:0]  prg_bank_r;
  logic [1:0]  mirror_mode_r;
  logic [15:0] irq_count_r, irq_count_nxt;
  logic        irq_on_r, irq_on_nxt, irq_pending_r, irq_pending_nxt;
  logic [7:0]  line_reg_r;
  cmse_pkg::serial_mode_t mode_r, mode_nxt;
  cmse_pkg::chip_kind_t   kind_r, kind_nxt;
  logic [3:0]  bit_count_r, bit_count_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  word_ptr_r, word_ptr_nxt;
  logic [7:0]  out_byte_r;
  logic        out_load_r, out_load_nxt; // out_byte is the RAM read data

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata, out_byte;

  logic          go;
  logic          ovalid_r;
  logic [7:0]    rd_r;
  logic          hit_r;
  logic [21:0]   paddr_r;
  logic [17:0]   caddr_r;

  assign clearing = !clr_cnt_r[AW];
  assign go       = q_valid && !clearing && (!ovalid_r || out_ch.ready);
  assign q_pop    = go;
  assign out_byte = out_load_r ? ram_rdata : out_byte_r;

  cmse_ram #(.WIDTH(8), .DEPTH(SAVE_BYTES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // serial engine
  always_comb begin
    logic [7:0] pv, nv, sb, rp;
    logic       rdir;
    mode_nxt      = mode_r;
    kind_nxt      = kind_r;
    bit_count_nxt = bit_count_r;
    shift_nxt     = shift_r;
    word_ptr_nxt  = word_ptr_r;
    out_load_nxt  = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = clr_cnt_r[AW-1:0];
    ram_wdata     = 8'd0;
    pv            = line_reg_r;
    nv            = q_cmd.data;
    sb            = 8'd0;
    rp            = 8'd0;
    rdir          = 1'b0;
    if (clearing) begin
      ram_we = 1'b1;
    end else if (go && q_cmd.wr_serial) begin
      if ((pv & nv & cmse_pkg::LN_SCL) != 0 && pv[6] && !nv[6]) begin
        mode_nxt      = cmse_pkg::MODE_STANDBY_END;
        bit_count_nxt = 4'd0;
        shift_nxt     = 8'd0;
      end
      if (mode_nxt != cmse_pkg::MODE_STANDBY) begin
        if ((pv & nv & cmse_pkg::LN_SCL) != 0 && !pv[6] && nv[6]) begin
          mode_nxt = cmse_pkg::MODE_STANDBY;
        end else if (pv[5] && !nv[5]) begin
          if (mode_nxt == cmse_pkg::MODE_STANDBY_END) begin
            mode_nxt = cmse_pkg::MODE_RW_SELECT;
          end else if (bit_count_nxt < 4'd8) begin
            if (mode_nxt != cmse_pkg::MODE_OUTPUT) begin
              if (nv[6]) begin
                if (kind_nxt == cmse_pkg::KIND_128)
                  shift_nxt = shift_nxt | (8'h01 << bit_count_nxt[2:0]);
                else
                  shift_nxt = shift_nxt | (8'h80 >> bit_count_nxt[2:0]);
              end
              bit_count_nxt = bit_count_nxt + 4'd1;
            end else if (nv[6]) begin
              bit_count_nxt = bit_count_nxt + 4'd1;
            end
          end else begin
            bit_count_nxt = bit_count_nxt + 4'd1;
          end
          if (bit_count_nxt == 4'd9) begin
            sb = shift_nxt;
            if (kind_nxt == cmse_pkg::KIND_UNKNOWN) begin
              if (sb[7:4] == 4'hA) begin
                kind_nxt = cmse_pkg::KIND_256;
              end else begin
                kind_nxt = cmse_pkg::KIND_128;
                sb       = cmse_pkg::mirror_byte(sb);
              end
            end
            priority case (mode_nxt)
              cmse_pkg::MODE_RW_SELECT: begin
                rp = word_ptr_nxt;
                if (kind_nxt == cmse_pkg::KIND_256) begin
                  rdir     = sb[0];
                  mode_nxt = rdir ? cmse_pkg::MODE_OUTPUT : cmse_pkg::MODE_WAIT_ADDRESS;
                end else begin
                  rdir         = sb[7];
                  word_ptr_nxt = {1'b0, sb[6:0]};
                  rp           = word_ptr_nxt;
                  mode_nxt     = rdir ? cmse_pkg::MODE_OUTPUT : cmse_pkg::MODE_WAIT_DATA;
                end
                if (rdir) begin
                  ram_addr     = rp[AW-1:0];
                  out_load_nxt = 1'b1;
                end
              end
              cmse_pkg::MODE_WAIT_ADDRESS: begin
                word_ptr_nxt = sb;
                mode_nxt     = cmse_pkg::MODE_WAIT_DATA;
              end
              cmse_pkg::MODE_WAIT_DATA: begin
                ram_we       = 1'b1;
                ram_addr     = word_ptr_nxt[AW-1:0];
                ram_wdata    = sb;
                word_ptr_nxt = {word_ptr_nxt[7:3], word_ptr_nxt[2:0] + 3'd1};
              end
              cmse_pkg::MODE_OUTPUT: begin
                word_ptr_nxt = word_ptr_nxt + 8'd1;
                ram_addr     = word_ptr_nxt[AW-1:0];
                out_load_nxt = 1'b1;
              end
              default: ;
            endcase
            bit_count_nxt = 4'd0;
            shift_nxt     = 8'd0;
          end
        end
      end
    end
  end

  // IRQ counter
  always_comb begin
    irq_count_nxt   = irq_count_r;
    irq_on_nxt      = irq_on_r;
    irq_pending_nxt = irq_pending_r;
    if (go && q_cmd.wr_low) begin
      unique case (q_cmd.nib)
        4'hA: begin
          irq_pending_nxt = 1'b0;
          irq_on_nxt      = q_cmd.data[0];
        end
        4'hB: irq_count_nxt = {irq_count_r[15:8], q_cmd.data};
        4'hC: irq_count_nxt = {q_cmd.data, irq_count_r[7:0]};
        default: ;
      endcase
    end else if (go && q_cmd.tick && irq_on_r) begin
      if (irq_count_r != 16'd0) begin
        irq_count_nxt = irq_count_r - 16'd1;
        if (irq_count_r == 16'd1) irq_pending_nxt = 1'b1;
      end else begin
        irq_count_nxt = 16'hFFFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r     <= '0;
      for (int i = 0; i < 8; i++) chr_banks_r[i] <= 8'd0;
      prg_bank_r    <= 8'd0;
      mirror_mode_r <= 2'd0;
      irq_count_r   <= 16'd0;
      irq_on_r      <= 1'b0;
      irq_pending_r <= 1'b0;
      line_reg_r    <= 8'd0;
      mode_r        <= cmse_pkg::MODE_STANDBY;
      kind_r        <= cmse_pkg::KIND_UNKNOWN;
      bit_count_r   <= 4'd0;
      shift_r       <= 8'd0;
      word_ptr_r    <= 8'd0;
      out_byte_r    <= 8'd0;
      out_load_r    <= 1'b0;
      ovalid_r      <= 1'b0;
    end else begin
      if (clearing) clr_cnt_r <= clr_cnt_r + 1'b1;
      irq_count_r   <= irq_count_nxt;
      irq_on_r      <= irq_on_nxt;
      irq_pending_r <= irq_pending_nxt;
      mode_r        <= mode_nxt;
      kind_r        <= kind_nxt;
      bit_count_r   <= bit_count_nxt;
      shift_r       <= shift_nxt;
      word_ptr_r    <= word_ptr_nxt;
      // capture RAM data once it has been read out
      if (out_load_r) out_byte_r <= ram_rdata;
      out_load_r    <= out_load_nxt;
      if (go && q_cmd.wr_serial) line_reg_r <= q_cmd.data;
      if (go && q_cmd.wr_low) begin
        if (!q_cmd.nib[3]) chr_banks_r[q_cmd.nib[2:0]] <= q_cmd.data;
        if (q_cmd.nib == 4'h8) prg_bank_r <= q_cmd.data;
        if (q_cmd.nib == 4'h9) mirror_mode_r <= q_cmd.data[1:0];
      end
      if (go) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (go) begin
      rd_r    <= 8'd0;
      hit_r   <= q_cmd.rd_prg;
      paddr_r <= 22'd0;
      caddr_r <= 18'd0;
      if (q_cmd.rd_save && mode_nxt == cmse_pkg::MODE_OUTPUT && bit_count_nxt <= 4'd8
          && line_reg_r[7:5] != 3'd0) begin
        if (kind_nxt == cmse_pkg::KIND_256)
          rd_r <= (bit_count_nxt[3] == 1'b0 && out_byte[3'd7 - bit_count_nxt[2:0]]) ?
                  8'h10 : 8'h00;
        else
          rd_r <= (bit_count_nxt[3] == 1'b0 && out_byte[bit_count_nxt[2:0]]) ? 8'h10 : 8'h00;
      end
      if (q_cmd.rd_prg)
        paddr_r <= {(q_cmd.address[14] ? 8'(prg_page_count - 9'd1) : prg_bank_r),
                    q_cmd.address[13:0]};
      if (q_cmd.rd_ppu)
        caddr_r <= chr_rom_present ?
                   {chr_banks_r[q_cmd.address[12:10]], q_cmd.address[9:0]} :
                   {5'd0, q_cmd.address[12:0]};
    end
  end

  assign out_ch.valid         = ovalid_r;
  assign out_ch.read_data     = rd_r;
  assign out_ch.prg_hit       = hit_r;
  assign out_ch.prg_address   = paddr_r;
  assign out_ch.chr_address   = caddr_r;
  assign out_ch.nametable_map = cmse_pkg::nt_map(mirror_mode_r);
  assign out_ch.irq_line      = irq_pending_r;
endmodule

// ===== hw/rtl/cartridge_mapper_with_serial_eeprom.sv =====
// ----------------------------------------------------------------------------
// cartridge_mapper_with_serial_eeprom
// Mapper with banked PRG/CHR, IRQ counter and bit-banged serial EEPROM.
// ----------------------------------------------------------------------------
// Path: an accepted request is held in the queue and then answered from the result register.
// Throughput: one request per cycle outside the clear sweep; the two-entry queue absorbs output stalls.
// Reset: synchronous; after reset the save store is cleared by a sweep over all
// SAVE_BYTES entries, during which the queue takes up to two requests and then the
// input stalls (configuration writes are taken).
module cartridge_mapper_with_serial_eeprom #(
  parameter int SAVE_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  cmse_in_if.sink    in_ch,
  cmse_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [cmse_pkg::CFG_DATA_W-1:0] cfg_data
);
  logic           q_valid, q_pop;
  cmse_pkg::cmd_t q_cmd;
  logic [8:0]     prg_page_count_r;
  logic           chr_rom_present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_page_count_r  <= 9'd16;
      chr_rom_present_r <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == cmse_pkg::CFG_PRG_PAGE_COUNT)  prg_page_count_r  <= cfg_data;
      if (cfg_index == cmse_pkg::CFG_CHR_ROM_PRESENT) chr_rom_present_r <= cfg_data[0];
    end
  end

  cmse_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  cmse_back #(.SAVE_BYTES(SAVE_BYTES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .prg_page_count(prg_page_count_r), .chr_rom_present(chr_rom_present_r),
    .out_ch(out_ch)
  );
endmodule
